FILE: src/nbd_pkg.sv
// NAT behavior discovery sequencer: shared types, codes and helpers.
// Used by nbd_step and nat_behavior_discovery_sequencer_core; no dependencies.
`default_nettype none

package nbd_pkg;

  // Address width of every IPv4 field (used by the payload structs)
  localparam int ADDR_BITS  = 32;
  localparam int PORT_BITS  = 16;
  localparam int CFG_DATA_W = ADDR_BITS;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_IP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_PORT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_SCOPE  = 2'd2;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EVENT = 1'b1;

  // Test scope codes
  localparam logic [1:0] SC_FULL = 2'd0;
  localparam logic [1:0] SC_BIND = 2'd1;
  localparam logic [1:0] SC_MAP  = 2'd2;
  localparam logic [1:0] SC_FILT = 2'd3;

  // Change request kinds
  localparam logic [1:0] CK_PLAIN   = 2'd0;
  localparam logic [1:0] CK_IP_PORT = 2'd1;
  localparam logic [1:0] CK_PORT    = 2'd2;

  // Binding verdicts
  localparam logic [1:0] BV_NONE    = 2'd0;
  localparam logic [1:0] BV_SUCCESS = 2'd1;
  localparam logic [1:0] BV_FAIL    = 2'd2;
  localparam logic [1:0] BV_UNSUPP  = 2'd3;

  // Mapping verdicts
  localparam logic [2:0] MV_NONE     = 3'd0;
  localparam logic [2:0] MV_DIRECT   = 3'd1;
  localparam logic [2:0] MV_EP_INDEP = 3'd2;
  localparam logic [2:0] MV_ADDR_DEP = 3'd3;
  localparam logic [2:0] MV_APORT_DEP = 3'd4;
  localparam logic [2:0] MV_FAIL     = 3'd5;
  localparam logic [2:0] MV_UNSUPP   = 3'd6;

  // Filtering verdicts
  localparam logic [2:0] FV_NONE      = 3'd0;
  localparam logic [2:0] FV_EP_INDEP  = 3'd1;
  localparam logic [2:0] FV_ADDR_DEP  = 3'd2;
  localparam logic [2:0] FV_APORT_DEP = 3'd3;
  localparam logic [2:0] FV_UNSUPP    = 3'd4;

  typedef enum logic [2:0] {
    PH_DONE  = 3'd0,
    PH_BIND  = 3'd1,
    PH_FILT2 = 3'd2,
    PH_FILT3 = 3'd3,
    PH_MAP2  = 3'd4,
    PH_MAP3  = 3'd5
  } phase_t;

  typedef struct packed {
    logic                 vld;
    logic [ADDR_BITS-1:0] ip;
    logic [PORT_BITS-1:0] port;
  } ep_t;

  typedef struct packed {
    phase_t     phase;
    ep_t        pub;
    ep_t        loc;
    ep_t        alt;
    ep_t        map2;
    logic [1:0] bind_v;
    logic [2:0] map_v;
    logic [2:0] filt_v;
  } nbd_state_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] server_ip;
    logic [PORT_BITS-1:0] server_port;
    logic [1:0]           test_scope;
  } nbd_cfg_t;

  typedef struct packed {
    logic                 command;
    logic                 response_present;
    logic                 has_mapped;
    logic [ADDR_BITS-1:0] mapped_ip;
    logic [PORT_BITS-1:0] mapped_port;
    logic                 has_other;
    logic [ADDR_BITS-1:0] other_ip;
    logic [PORT_BITS-1:0] other_port;
    logic [ADDR_BITS-1:0] local_ip;
    logic [PORT_BITS-1:0] local_port;
    logic [ADDR_BITS-1:0] remote_ip;
    logic [PORT_BITS-1:0] remote_port;
  } nbd_in_t;

  typedef struct packed {
    logic                 request_valid;
    logic [ADDR_BITS-1:0] request_ip;
    logic [PORT_BITS-1:0] request_port;
    logic [1:0]           change_kind;
    logic                 finished;
    logic [1:0]           binding_verdict;
    logic [2:0]           mapping_verdict;
    logic [2:0]           filtering_verdict;
    logic [ADDR_BITS-1:0] public_ip;
    logic [PORT_BITS-1:0] public_port;
  } nbd_out_t;

  // Build an endpoint; an absent one reads as zero
  function automatic ep_t ep_mk(input logic v, input logic [ADDR_BITS-1:0] ip,
                                input logic [PORT_BITS-1:0] port);
    ep_t e;
    e.vld  = v;
    e.ip   = v ? ip : '0;
    e.port = v ? port : '0;
    return e;
  endfunction

  // Compare address and port only
  function automatic logic ep_eq(input ep_t a, input ep_t b);
    return (a.ip == b.ip) && (a.port == b.port);
  endfunction

endpackage

`default_nettype wire

FILE: src/nbd_step.sv
// Step logic: next discovery state and the result for one event.
// Depends on nbd_pkg; purely combinational.
`default_nettype none

module nbd_step (
  input  nbd_pkg::nbd_in_t    item,
  input  nbd_pkg::nbd_cfg_t   cfg,
  input  nbd_pkg::nbd_state_t st,
  output nbd_pkg::nbd_state_t st_nxt,
  output nbd_pkg::nbd_out_t   res
);
  import nbd_pkg::*;

  logic       resp;
  ep_t        mapped;
  ep_t        other;
  ep_t        remote;
  ep_t        zero_ep;
  logic       alt_ok;
  logic       direct_new;
  logic       direct_old;
  logic [1:0] bv;
  logic [2:0] fv;

  // Decode the event's endpoints; a timeout hides all reply fields
  always_comb begin
    resp    = item.response_present;
    mapped  = ep_mk(resp & item.has_mapped, item.mapped_ip, item.mapped_port);
    other   = ep_mk(resp & item.has_other, item.other_ip, item.other_port);
    remote  = ep_mk(resp, item.remote_ip, item.remote_port);
    zero_ep = ep_mk(1'b0, '0, '0);
  end

  // Advance the discovery phase
  always_comb begin
    st_nxt = st;
    res    = '0;
    bv     = BV_NONE;
    fv     = FV_NONE;
    alt_ok = other.vld && (other.ip != cfg.server_ip) && (other.port != cfg.server_port);
    // direct test on the endpoints taken from this reply
    direct_new = mapped.vld && resp && ep_eq(mapped, ep_mk(resp, item.local_ip,
                                                           item.local_port));
    // direct test on stored endpoints
    direct_old = st.pub.vld && st.loc.vld && ep_eq(st.pub, st.loc);

    if (item.command == CMD_START) begin
      st_nxt.pub    = zero_ep;
      st_nxt.loc    = zero_ep;
      st_nxt.alt    = zero_ep;
      st_nxt.map2   = zero_ep;
      st_nxt.bind_v = BV_NONE;
      st_nxt.map_v  = MV_NONE;
      st_nxt.filt_v = FV_NONE;
      st_nxt.phase  = PH_BIND;
      res.request_valid = 1'b1;
      res.request_ip    = cfg.server_ip;
      res.request_port  = cfg.server_port;
      res.change_kind   = CK_PLAIN;
    end else begin
      case (st.phase)
        PH_BIND: begin
          if (!resp)
            bv = BV_FAIL;
          else if (!mapped.vld)
            bv = BV_UNSUPP;
          else
            bv = BV_SUCCESS;
          st_nxt.bind_v = bv;
          st_nxt.loc    = ep_mk(resp, item.local_ip, item.local_port);
          st_nxt.pub    = mapped;
          st_nxt.alt    = other;
          if (cfg.test_scope == SC_BIND || bv != BV_SUCCESS) begin
            st_nxt.phase = PH_DONE;
          end else if (!alt_ok) begin
            if (cfg.test_scope == SC_FILT || cfg.test_scope == SC_FULL)
              st_nxt.filt_v = FV_UNSUPP;
            if (cfg.test_scope == SC_MAP)
              st_nxt.map_v = MV_UNSUPP;
            st_nxt.phase = PH_DONE;
          end else if (cfg.test_scope == SC_MAP) begin
            if (direct_new) begin
              st_nxt.map_v = MV_DIRECT;
              st_nxt.phase = PH_DONE;
            end else begin
              st_nxt.phase      = PH_MAP2;
              res.request_valid = 1'b1;
              res.request_ip    = other.ip;
              res.request_port  = cfg.server_port;
              res.change_kind   = CK_PLAIN;
            end
          end else begin
            st_nxt.phase      = PH_FILT2;
            res.request_valid = 1'b1;
            res.request_ip    = cfg.server_ip;
            res.request_port  = cfg.server_port;
            res.change_kind   = CK_IP_PORT;
          end
        end
        PH_FILT2, PH_FILT3: begin
          if (st.phase == PH_FILT2 && !resp) begin
            st_nxt.phase      = PH_FILT3;
            res.request_valid = 1'b1;
            res.request_ip    = cfg.server_ip;
            res.request_port  = cfg.server_port;
            res.change_kind   = CK_PORT;
          end else begin
            if (st.phase == PH_FILT2)
              fv = (st.alt.vld && ep_eq(remote, st.alt)) ? FV_EP_INDEP : FV_UNSUPP;
            else if (!resp)
              fv = FV_APORT_DEP;
            else if (remote.ip == cfg.server_ip && remote.port != cfg.server_port)
              fv = FV_ADDR_DEP;
            else
              fv = FV_UNSUPP;
            st_nxt.filt_v = fv;
            // continue with mapping only on a full run with usable filtering
            if (cfg.test_scope == SC_FULL && fv != FV_UNSUPP) begin
              if (direct_old) begin
                st_nxt.map_v = MV_DIRECT;
                st_nxt.phase = PH_DONE;
              end else begin
                st_nxt.phase      = PH_MAP2;
                res.request_valid = 1'b1;
                res.request_ip    = st.alt.ip;
                res.request_port  = cfg.server_port;
                res.change_kind   = CK_PLAIN;
              end
            end else begin
              st_nxt.phase = PH_DONE;
            end
          end
        end
        PH_MAP2: begin
          if (!mapped.vld) begin
            st_nxt.map_v = MV_FAIL;
            st_nxt.phase = PH_DONE;
          end else if (st.pub.vld && ep_eq(mapped, st.pub)) begin
            st_nxt.map_v = MV_EP_INDEP;
            st_nxt.phase = PH_DONE;
          end else begin
            st_nxt.map2       = mapped;
            st_nxt.phase      = PH_MAP3;
            res.request_valid = 1'b1;
            res.request_ip    = st.alt.ip;
            res.request_port  = st.alt.port;
            res.change_kind   = CK_PLAIN;
          end
        end
        PH_MAP3: begin
          if (!mapped.vld)
            st_nxt.map_v = MV_FAIL;
          else if (st.map2.vld && ep_eq(mapped, st.map2))
            st_nxt.map_v = MV_ADDR_DEP;
          else
            st_nxt.map_v = MV_APORT_DEP;
          st_nxt.phase = PH_DONE;
        end
        default: begin
          st_nxt.phase = PH_DONE;
        end
      endcase
    end

    // Report verdicts after this step
    res.finished          = (st_nxt.phase == PH_DONE);
    res.binding_verdict   = st_nxt.bind_v;
    res.mapping_verdict   = st_nxt.map_v;
    res.filtering_verdict = st_nxt.filt_v;
    res.public_ip         = st_nxt.pub.ip;
    res.public_port       = st_nxt.pub.port;
  end

endmodule

`default_nettype wire

FILE: src/nat_behavior_discovery_sequencer_core.sv
// Top level of the NAT behavior discovery sequencer: config registers,
// input register, discovery state, result register. Depends on nbd_pkg, nbd_step.
//
//   Channel | Ports                              | Moves
//   --------+------------------------------------+-----------------------------------
//   in      | in_valid, in_ready, in_data        | one start command or reply/timeout
//   out     | out_valid, out_ready, out_data     | one result per input transfer
//   cfg     | cfg_we, cfg_idx, cfg_data          | register write, no wait, no read
//
// One item per cycle sustained while out_ready stays high; a result passes from
// the input register through the step logic into the result register before
// it is offered.
// Reset (rst_n low, synchronous) clears the config, valid and state registers and sets the phase to done.
// With out_ready low the result register holds and the input register still
// takes one more item; in_ready then drops until the result is taken.
`default_nettype none

module nat_behavior_discovery_sequencer_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  nbd_pkg::nbd_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output nbd_pkg::nbd_out_t                    out_data,
  input  logic                                 cfg_we,
  input  logic [nbd_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [nbd_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import nbd_pkg::*;

  nbd_cfg_t   cfg_r;
  nbd_in_t    in_r;
  logic       in_vld_r;
  nbd_state_t state_r;
  nbd_state_t state_nxt;
  nbd_out_t   out_r;
  nbd_out_t   res_nxt;
  logic       out_vld_r;
  logic       move;

  // Move an item from the input register to the result register
  assign move     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || move;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SERVER_IP:   cfg_r.server_ip   <= cfg_data[ADDR_BITS-1:0];
        CFG_SERVER_PORT: cfg_r.server_port <= cfg_data[PORT_BITS-1:0];
        CFG_TEST_SCOPE:  cfg_r.test_scope  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  nbd_step u_step (
    .item   (in_r),
    .cfg    (cfg_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // Commit the step: discovery state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // all-zero state is the done phase with no endpoints and no verdicts
      state_r       <= '0;
      out_vld_r     <= 1'b0;
    end else begin
      if (move) begin
        state_r <= state_nxt;
      end
      if (move) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_r <= res_nxt;
    end
  end

  // A finished result never carries a request
  a_done_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.finished) |-> !out_r.request_valid)
    else $error("finished result carries a request");

  // No request means zero target and plain kind
  a_idle_req_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.request_valid) |->
      (out_r.request_ip == '0 && out_r.request_port == '0 &&
       out_r.change_kind == CK_PLAIN))
    else $error("request fields set without a request");

  // A start clears the verdicts and asks for a binding request
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (move && in_r.command == CMD_START) |=>
      (out_r.request_valid && out_r.binding_verdict == BV_NONE &&
       out_r.mapping_verdict == MV_NONE && out_r.filtering_verdict == FV_NONE &&
       state_r.phase == PH_BIND))
    else $error("start did not restart discovery");

  // Reset leaves the sequencer done with nothing pending
  a_reset_state: assert property (@(posedge clk)
    ($past(rst_n) == 1'b0) |-> (state_r.phase == PH_DONE && !out_vld_r && !in_vld_r))
    else $error("state not cleared by reset");

endmodule

`default_nettype wire
